// ===== sv/pssg_pkg.sv =====
package pssg_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_SYMBOLS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHICH_FACTOR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UE_IDENTIFIER = 4'd3;

    localparam logic [6:0] BANDWIDTH_RESET = 7'd100;
    localparam logic [1:0] CONTROL_SYMBOLS_RESET = 2'd3;
    localparam logic [1:0] PHICH_FACTOR_RESET = 2'd1;
    localparam logic [15:0] UE_IDENTIFIER_RESET = 16'd12;

    // Hash multiplier; the modulus is 2^16 + 1 and is folded in the datapath.
    localparam logic [15:0] HASH_A = 16'd39827;
    localparam logic [16:0] HASH_D = 17'd65537;

    // Reciprocal of nine scaled by 2^12, slightly below the true value.
    localparam logic [18:0] RECIP_9 = 19'd455;

    localparam logic [2:0] LAST_LEVEL = 3'd5;
    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGS,
        ST_COUNT,
        ST_HMUL,
        ST_HRED,
        ST_LEVEL,
        ST_DIV,
        ST_EMIT
    } pssg_state_t;

    typedef struct packed {
        logic       hash_load;
        logic       load_regs;
        logic       load_count;
        logic       hash_mul;
        logic       hash_red;
        logic       level_load;
        logic       div_step;
        logic       emit;
        logic [2:0] level;
        logic [2:0] cand;
        logic       last;
    } pssg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic slots_zero;
    } pssg_status_t;

    // Levels in output order: common 4 and 8, then UE-specific 1, 2, 4 and 8.
    function automatic logic [1:0] lvl_log2(input logic [2:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0: r = 2'd2;
            3'd1: r = 2'd3;
            3'd2: r = 2'd0;
            3'd3: r = 2'd1;
            3'd4: r = 2'd2;
            3'd5: r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lvl_count(input logic [2:0] idx);
        logic [2:0] r;
        unique case (idx)
            3'd0: r = 3'd4;
            3'd1: r = 3'd2;
            3'd2: r = 3'd6;
            3'd3: r = 3'd6;
            3'd4: r = 3'd2;
            3'd5: r = 3'd2;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic lvl_space(input logic [2:0] idx);
        return (idx >= 3'd2);
    endfunction

endpackage

// ===== sv/pssg_if.sv =====
interface pssg_req_if
    import pssg_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [3:0] subframe_number;

    modport source (output valid, output subframe_number, input ready);
    modport sink (input valid, input subframe_number, output ready);
endinterface

interface pssg_cand_if
    import pssg_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       space_kind;
    logic [1:0] level_code;
    logic [2:0] candidate_number;
    logic [6:0] first_cce;
    logic [6:0] cce_total;
    logic       candidate_valid;
    logic       last_of_run;

    modport source (output valid, output space_kind, output level_code,
                    output candidate_number, output first_cce, output cce_total,
                    output candidate_valid, output last_of_run, input ready);
    modport sink (input valid, input space_kind, input level_code,
                  input candidate_number, input first_cce, input cce_total,
                  input candidate_valid, input last_of_run, output ready);
endinterface

interface pssg_cfg_if
    import pssg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pdcch_search_space_generator_top.sv =====
// PDCCH search space generator. Each accepted request word carries a subframe
// number k and produces 22 candidate words in a fixed order: the common search
// space (level 4 with four candidates, level 8 with two) and then the
// UE-specific space (levels 1, 2, 4 and 8 with six, six, two and two). Every
// candidate word carries its first CCE, the CCE count of the control region and
// a valid flag that is low when the region holds fewer CCEs than the level
// needs; the final word of a run has last_of_run set. The accepted word is
// taken in the idle state, the REG count and then the CCE count are
// registered, the hash runs k + 1 iterations of a multiply state and a fold
// state, each of the six levels has a setup state, each UE-specific level
// with usable slots then passes through a bit-serial remainder unit, and the
// candidates are issued at one word per cycle while the output register is
// free. A UE-specific level without usable slots skips the remainder unit.
// One request is in flight at a time; the next is taken once the last
// candidate word has been loaded into the output register.

module pdcch_search_space_generator_top
    import pssg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pssg_cfg_if.sink     cfg,
    pssg_req_if.sink     req,
    pssg_cand_if.source  cand
);

    // The controller sequences the hash iterations, the level setup, the
    // remainder steps and the candidate issue; the datapath holds the
    // configuration, the arithmetic and the output register.
    pssg_cmd_t    cmd;
    pssg_status_t status;

    pssg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status)
    );

    pssg_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cand   (cand),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// ===== sv/pssg_ctrl.sv =====
module pssg_ctrl
    import pssg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pssg_req_if.sink      req,
    output pssg_cmd_t     cmd,
    input  pssg_status_t  status
);

    pssg_state_t state_reg, state_next;
    logic [3:0]  k_reg, k_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [2:0]  level_reg, level_next;
    logic [2:0]  cand_reg, cand_next;
    logic        cand_end;

    assign cand_end = (cand_reg == (lvl_count(level_reg) - 3'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
            level_reg <= '0;
            cand_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            level_reg <= level_next;
            cand_reg  <= cand_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        level_next = level_reg;
        cand_next  = cand_reg;
        cmd        = '0;
        cmd.level  = level_reg;
        cmd.cand   = cand_reg;
        cmd.last   = (level_reg == LAST_LEVEL) && cand_end;
        req.ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    k_next        = req.subframe_number;
                    cmd.hash_load = 1'b1;
                    state_next    = ST_REGS;
                end
            end
            ST_REGS:
            begin
                cmd.load_regs = 1'b1;
                state_next    = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.load_count = 1'b1;
                cnt_next       = '0;
                state_next     = ST_HMUL;
            end
            ST_HMUL:
            begin
                cmd.hash_mul = 1'b1;
                state_next   = ST_HRED;
            end
            ST_HRED:
            begin
                cmd.hash_red = 1'b1;
                if (cnt_reg[3:0] == k_reg)
                begin
                    level_next = '0;
                    state_next = ST_LEVEL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_LEVEL:
            begin
                cmd.level_load = 1'b1;
                cand_next      = '0;
                cnt_next       = '0;
                if (lvl_space(level_reg) && !status.slots_zero)
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_STEPS - 5'd1)
                    state_next = ST_EMIT;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cand_end)
                    begin
                        if (level_reg == LAST_LEVEL)
                            state_next = ST_IDLE;
                        else
                        begin
                            level_next = level_reg + 3'd1;
                            state_next = ST_LEVEL;
                        end
                    end
                    else
                        cand_next = cand_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("candidate word issued while the output register is full");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its final candidate");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < DIV_STEPS))
        else $error("remainder step count overran");

endmodule

// ===== sv/pssg_dp.sv =====
module pssg_dp
    import pssg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pssg_cfg_if.sink      cfg,
    pssg_cand_if.source   cand,
    input  pssg_cmd_t     cmd,
    output pssg_status_t  status
);

    // Configuration registers.
    logic [6:0]  bw_reg;
    logic [1:0]  cs_reg;
    logic [1:0]  pf_reg;
    logic [15:0] ue_reg;

    // Working registers.
    logic [9:0]  regs_reg, regs_next;
    logic [6:0]  n_cce_reg, n_cce_next;
    logic [16:0] y_reg, y_next;
    logic [32:0] prod_reg;
    logic [16:0] div_reg, div_next;
    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  slots_reg;
    logic [1:0]  lc_reg;
    logic        space_reg;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [1:0]  code_reg;
    logic [2:0]  num_reg;
    logic [6:0]  first_reg;
    logic [6:0]  total_reg;
    logic        cvalid_reg;
    logic        last_reg;

    // REG count.
    logic [4:0]         g_sum;
    logic [3:0]         groups;
    logic [3:0]         cs_x3;
    logic [3:0]         pf_x3;
    logic signed [4:0]  mult;
    logic signed [12:0] mult_ext;
    logic signed [12:0] bw_ext;
    logic signed [12:0] bw_prod;
    logic [7:0]         phich_term;
    logic signed [12:0] regs_s;

    // Division by nine.
    logic [18:0] q_prod;
    logic [6:0]  q0;
    logic [10:0] q0_x9;
    logic [10:0] q_rem;

    // Hash fold.
    logic [17:0] fold;
    logic [17:0] fold_fix;

    // Per level.
    logic [1:0]  lc_sel;
    logic [6:0]  slots_sel;
    logic [7:0]  partial;
    logic [7:0]  rem_inc;
    logic [9:0]  first_sh;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= BANDWIDTH_RESET;
            cs_reg <= CONTROL_SYMBOLS_RESET;
            pf_reg <= PHICH_FACTOR_RESET;
            ue_reg <= UE_IDENTIFIER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BANDWIDTH:       bw_reg <= cfg.data[6:0];
                CFG_CONTROL_SYMBOLS: cs_reg <= cfg.data[1:0];
                CFG_PHICH_FACTOR:    pf_reg <= cfg.data[1:0];
                CFG_UE_IDENTIFIER:   ue_reg <= cfg.data[15:0];
                default:             ;
            endcase
        end
    end

    // REGs = (3*CFI - 1) * bandwidth - 4 - 3 * mi * groups, clamped at zero.
    always_comb
    begin
        g_sum      = {1'b0, bw_reg[6:3]} + 5'd1;
        groups     = g_sum[4:1];
        cs_x3      = {2'b00, cs_reg} + {1'b0, cs_reg, 1'b0};
        pf_x3      = {2'b00, pf_reg} + {1'b0, pf_reg, 1'b0};
        mult       = signed'({1'b0, cs_x3}) - 5'sd1;
        mult_ext   = {{8{mult[4]}}, mult};
        bw_ext     = signed'({6'b0, bw_reg});
        bw_prod    = mult_ext * bw_ext;
        phich_term = {4'b0, pf_x3} * {4'b0, groups};
        regs_s     = bw_prod - 13'sd4 - signed'({5'b0, phich_term});
        regs_next  = regs_s[12] ? 10'd0 : regs_s[9:0];
    end

    // The scaled reciprocal undershoots by at most one; one compare fixes it.
    always_comb
    begin
        q_prod     = {9'b0, regs_reg} * RECIP_9;
        q0         = q_prod[18:12];
        q0_x9      = {1'b0, q0, 3'b000} + {4'b0, q0};
        q_rem      = {1'b0, regs_reg} - q0_x9;
        n_cce_next = (q_rem >= 11'd9) ? q0 + 7'd1 : q0;
    end

    // Modulo 2^16 + 1: the high half is subtracted from the low half.
    always_comb
    begin
        fold     = {2'b00, prod_reg[15:0]} - {1'b0, prod_reg[32:16]};
        fold_fix = fold + {1'b0, HASH_D};
        if (cmd.hash_load)
            y_next = {1'b0, ue_reg};
        else if (cmd.hash_red)
            y_next = fold[17] ? fold_fix[16:0] : fold[16:0];
        else
            y_next = y_reg;
    end

    assign lc_sel    = lvl_log2(cmd.level);
    assign slots_sel = n_cce_reg >> lc_sel;
    assign partial   = {rem_reg, div_reg[16]};
    assign rem_inc   = {1'b0, rem_reg} + 8'd1;
    assign first_sh  = {3'b000, rem_reg} << lc_reg;

    always_comb
    begin
        rem_next = rem_reg;
        div_next = div_reg;
        if (cmd.level_load)
        begin
            rem_next = '0;
            div_next = y_reg;
        end
        else if (cmd.div_step)
        begin
            div_next = {div_reg[15:0], 1'b0};
            if (partial >= {1'b0, slots_reg})
                rem_next = 7'(partial - {1'b0, slots_reg});
            else
                rem_next = partial[6:0];
        end
        else if (cmd.emit)
        begin
            if (slots_reg == 7'd0 || rem_inc == {1'b0, slots_reg})
                rem_next = '0;
            else
                rem_next = rem_inc[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        if (cmd.load_regs)
            regs_reg <= regs_next;
        if (cmd.load_count)
            n_cce_reg <= n_cce_next;
        if (cmd.hash_mul)
            prod_reg <= {16'b0, y_reg} * {17'b0, HASH_A};
        if (cmd.level_load)
        begin
            lc_reg    <= lc_sel;
            slots_reg <= slots_sel;
            space_reg <= lvl_space(cmd.level);
        end
    end

    assign status.out_free   = !out_valid_reg || cand.ready;
    assign status.slots_zero = (slots_sel == 7'd0);

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (cand.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg   <= space_reg;
            code_reg   <= lc_reg;
            num_reg    <= cmd.cand;
            first_reg  <= first_sh[6:0];
            total_reg  <= n_cce_reg;
            cvalid_reg <= (slots_reg != 7'd0);
            last_reg   <= cmd.last;
        end
    end

    assign cand.valid            = out_valid_reg;
    assign cand.space_kind       = kind_reg;
    assign cand.level_code       = code_reg;
    assign cand.candidate_number = num_reg;
    assign cand.first_cce        = first_reg;
    assign cand.cce_total        = total_reg;
    assign cand.candidate_valid  = cvalid_reg;
    assign cand.last_of_run      = last_reg;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && slots_reg != 7'd0) |-> (rem_reg < slots_reg))
        else $error("candidate offset not below the slot count");

    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cand.ready) |=> (out_valid_reg && $stable(first_reg)))
        else $error("pending candidate word changed before it was taken");

    a_first_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cvalid_reg) |-> (first_reg < total_reg))
        else $error("usable candidate starts outside the control region");

endmodule
